>>> rtl/block_buffer_tag_table_macros.svh
// assertion macros for the buffer tag table checker
// no dependencies; taken in by the checker file
`ifndef BLOCK_BUFFER_TAG_TABLE_MACROS_SVH
`define BLOCK_BUFFER_TAG_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BBTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BBTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bbtt_pkg.sv
// shared constants, codes and controller/datapath types of the buffer tag table
// no dependencies
package bbtt_pkg;

    localparam int BUFFER_COUNT_DEF = 32;

    // field widths
    localparam int CMD_W       = 2;
    localparam int DEV_W       = 8;
    localparam int BLK_W       = 32;
    localparam int IDX_FIELD_W = 5;
    localparam int SLOT_W      = 5;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = 8;

    typedef logic [CMD_W-1:0]       t_cmd;
    typedef logic [DEV_W-1:0]       t_dev;
    typedef logic [BLK_W-1:0]       t_blk;
    typedef logic [IDX_FIELD_W-1:0] t_idx_field;
    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [STATUS_W-1:0]    t_status;
    typedef logic [CNT_W-1:0]       t_cnt;

    // request commands
    localparam t_cmd CMD_GET     = 2'd0;
    localparam t_cmd CMD_RELEASE = 2'd1;
    localparam t_cmd CMD_PIN     = 2'd2;
    localparam t_cmd CMD_UNPIN   = 2'd3;

    // result status codes
    localparam t_status ST_HIT     = 3'd0;
    localparam t_status ST_MISS    = 3'd1;
    localparam t_status ST_NOFREE  = 3'd2;
    localparam t_status ST_UPDATED = 3'd3;
    localparam t_status ST_ERROR   = 3'd4;

    localparam t_cnt COUNT_MAX = 8'hFF;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted request
        logic scan;     // issue the next slot read of a lookup scan
        logic wb_get;   // resolve a get, update the table, load the result
        logic wb_upd;   // resolve a count update, load the result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;  // the scan read now issued is for the last slot
    } t_dp_sts;

endpackage

>>> rtl/bbtt_if.sv
// valid/ready channel interfaces for requests and results of the buffer tag table
// depends on bbtt_pkg
interface bbtt_req_if;
    logic                  valid;
    logic                  ready;
    bbtt_pkg::t_cmd        command;
    bbtt_pkg::t_dev        device;
    bbtt_pkg::t_blk        block_number;
    bbtt_pkg::t_idx_field  buffer_index;

    modport source (output valid, output command, output device, output block_number,
                    output buffer_index, input ready);
    modport sink   (input valid, input command, input device, input block_number,
                    input buffer_index, output ready);
endinterface

interface bbtt_rsp_if;
    logic                valid;
    logic                ready;
    bbtt_pkg::t_slot     slot;
    bbtt_pkg::t_status   status;
    logic                needs_disk_read;
    bbtt_pkg::t_cnt      reference_count;

    modport source (output valid, output slot, output status, output needs_disk_read,
                    output reference_count, input ready);
    modport sink   (input valid, input slot, input status, input needs_disk_read,
                    input reference_count, output ready);
endinterface

>>> rtl/bbtt_ctrl.sv
// controller state machine of the buffer tag table: sequences scan and write-back
// depends on bbtt_pkg
module bbtt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bbtt_pkg::t_cmd    i_command,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output bbtt_pkg::t_dp_cmd o_dp_cmd,
    input  bbtt_pkg::t_dp_sts i_dp_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_GWB   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_UWB   = 3'd5;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_out_vld;
    logic              n_out_vld;
    logic              out_free;
    bbtt_pkg::t_dp_cmd dp_cmd;

    assign out_free = !r_out_vld || i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        dp_cmd  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    dp_cmd.load = 1'b1;
                    n_state = (i_command == bbtt_pkg::CMD_GET) ? S_SCAN : S_RD;
                end
            end
            S_SCAN: begin
                dp_cmd.scan = 1'b1;
                if (i_dp_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_GWB;
            end
            S_GWB: begin
                if (out_free) begin
                    dp_cmd.wb_get = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_UWB;
            end
            S_UWB: begin
                if (out_free) begin
                    dp_cmd.wb_upd = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid flag of the output register
    assign n_out_vld = (r_out_vld && !i_out_ready) || dp_cmd.wb_get || dp_cmd.wb_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_dp_cmd    = dp_cmd;

endmodule

>>> rtl/bbtt_dp.sv
// datapath of the buffer tag table: tag and count memories, slot flags,
// scan bookkeeping, victim pointer and the result register; depends on bbtt_pkg
module bbtt_dp #(
    parameter int BUFFER_COUNT = bbtt_pkg::BUFFER_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bbtt_pkg::t_dp_cmd    i_dp_cmd,
    output bbtt_pkg::t_dp_sts    o_dp_sts,
    input  bbtt_pkg::t_cmd       i_command,
    input  bbtt_pkg::t_dev       i_device,
    input  bbtt_pkg::t_blk       i_block_number,
    input  bbtt_pkg::t_idx_field i_buffer_index,
    output bbtt_pkg::t_slot      o_slot,
    output bbtt_pkg::t_status    o_status,
    output logic                 o_needs_disk_read,
    output bbtt_pkg::t_cnt       o_reference_count
);

    localparam int IDX_W = $clog2(BUFFER_COUNT);
    localparam int CMP_W = (IDX_W + 1 > bbtt_pkg::IDX_FIELD_W) ? IDX_W + 1
                                                               : bbtt_pkg::IDX_FIELD_W;
    localparam int TAG_W = bbtt_pkg::DEV_W + bbtt_pkg::BLK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_COUNT - 1);

    // captured request
    bbtt_pkg::t_cmd       r_cmd;
    bbtt_pkg::t_dev       r_dev;
    bbtt_pkg::t_blk       r_blk;
    bbtt_pkg::t_idx_field r_idx;

    // table storage
    logic [TAG_W-1:0]     mem_tag [BUFFER_COUNT];
    bbtt_pkg::t_cnt       mem_cnt [BUFFER_COUNT];
    logic [BUFFER_COUNT-1:0] r_present;
    logic [BUFFER_COUNT-1:0] r_dvalid;
    logic [BUFFER_COUNT-1:0] r_live;
    logic [IDX_W-1:0]     r_vp;

    // read pipeline
    logic [IDX_W-1:0]     r_scan;
    logic [IDX_W-1:0]     rd_addr;
    logic [TAG_W-1:0]     r_tag_q;
    bbtt_pkg::t_cnt       r_cnt_raw_q;
    logic                 r_live_q;
    logic                 r_pres_q;
    logic                 r_dv_q;
    logic [IDX_W-1:0]     r_eval_idx;
    logic                 r_eval_vld;
    bbtt_pkg::t_cnt       cnt_q;

    // scan results
    logic                 r_hit_found;
    logic [IDX_W-1:0]     r_hit_idx;
    bbtt_pkg::t_cnt       r_hit_cnt;
    logic                 r_hit_dv;
    logic                 r_fhi_found;
    logic [IDX_W-1:0]     r_fhi_idx;
    logic                 r_flo_found;
    logic [IDX_W-1:0]     r_flo_idx;
    logic                 eval_match;
    logic                 eval_free;

    // write-back
    logic                 idx_ok;
    logic [IDX_W-1:0]     idx_cur;
    logic [IDX_W-1:0]     free_sel;
    logic                 free_any;
    logic [IDX_W-1:0]     waddr;
    logic                 cnt_we;
    bbtt_pkg::t_cnt       cnt_wdata;
    logic                 tag_we;
    logic                 set_dv;
    logic                 vp_we;
    bbtt_pkg::t_slot      res_slot;
    bbtt_pkg::t_status    res_status;
    logic                 res_rd;
    bbtt_pkg::t_cnt       res_cnt;

    // result register
    bbtt_pkg::t_slot      r_slot;
    bbtt_pkg::t_status    r_status;
    logic                 r_rd;
    bbtt_pkg::t_cnt       r_cnt;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd <= i_command;
            r_dev <= i_device;
            r_blk <= i_block_number;
            r_idx <= i_buffer_index;
        end
    end

    // scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_dp_cmd.load) begin
            r_scan <= '0;
        end else if (i_dp_cmd.scan) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    assign o_dp_sts.scan_last = (r_scan == LAST_IDX);
    assign idx_cur = IDX_W'(r_idx);
    assign idx_ok  = CMP_W'(r_idx) < CMP_W'(BUFFER_COUNT);
    assign rd_addr = i_dp_cmd.scan ? r_scan : idx_cur;

    // registered memory and flag reads, one slot a cycle
    always_ff @(posedge i_clk) begin
        r_tag_q     <= mem_tag[rd_addr];
        r_cnt_raw_q <= mem_cnt[rd_addr];
        r_live_q    <= r_live[rd_addr];
        r_pres_q    <= r_present[rd_addr];
        r_dv_q      <= r_dvalid[rd_addr];
        r_eval_idx  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_vld <= 1'b0;
        end else begin
            r_eval_vld <= i_dp_cmd.scan;
        end
    end

    // a count never written reads as zero
    assign cnt_q      = r_live_q ? r_cnt_raw_q : '0;
    assign eval_match = r_pres_q && (r_tag_q == {r_dev, r_blk});
    assign eval_free  = (cnt_q == '0);

    // lowest matching slot, first free slot at or after the victim pointer,
    // first free slot below it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found <= 1'b0;
            r_fhi_found <= 1'b0;
            r_flo_found <= 1'b0;
        end else if (i_dp_cmd.load) begin
            r_hit_found <= 1'b0;
            r_fhi_found <= 1'b0;
            r_flo_found <= 1'b0;
        end else if (r_eval_vld) begin
            if (eval_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
            end
            if (eval_free && !r_fhi_found && (r_eval_idx >= r_vp)) begin
                r_fhi_found <= 1'b1;
            end
            if (eval_free && !r_flo_found && (r_eval_idx < r_vp)) begin
                r_flo_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_eval_vld) begin
            if (eval_match && !r_hit_found) begin
                r_hit_idx <= r_eval_idx;
                r_hit_cnt <= cnt_q;
                r_hit_dv  <= r_dv_q;
            end
            if (eval_free && !r_fhi_found && (r_eval_idx >= r_vp)) begin
                r_fhi_idx <= r_eval_idx;
            end
            if (eval_free && !r_flo_found && (r_eval_idx < r_vp)) begin
                r_flo_idx <= r_eval_idx;
            end
        end
    end

    assign free_any = r_fhi_found || r_flo_found;
    assign free_sel = r_fhi_found ? r_fhi_idx : r_flo_idx;

    // resolve the request and form the table update and result
    always_comb begin
        waddr      = r_hit_idx;
        cnt_we     = 1'b0;
        cnt_wdata  = '0;
        tag_we     = 1'b0;
        set_dv     = 1'b0;
        vp_we      = 1'b0;
        res_slot   = '0;
        res_status = bbtt_pkg::ST_NOFREE;
        res_rd     = 1'b0;
        res_cnt    = '0;
        if (i_dp_cmd.wb_get) begin
            if (r_hit_found) begin
                res_slot = bbtt_pkg::SLOT_W'(r_hit_idx);
                if (r_hit_cnt == bbtt_pkg::COUNT_MAX) begin
                    res_status = bbtt_pkg::ST_ERROR;
                    res_cnt    = r_hit_cnt;
                end else begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = r_hit_cnt + 1'b1;
                    set_dv     = 1'b1;
                    res_status = bbtt_pkg::ST_HIT;
                    res_rd     = !r_hit_dv;
                    res_cnt    = cnt_wdata;
                end
            end else if (free_any) begin
                waddr      = free_sel;
                tag_we     = 1'b1;
                cnt_we     = 1'b1;
                cnt_wdata  = bbtt_pkg::CNT_W'(1);
                set_dv     = 1'b1;
                vp_we      = 1'b1;
                res_slot   = bbtt_pkg::SLOT_W'(free_sel);
                res_status = bbtt_pkg::ST_MISS;
                res_rd     = 1'b1;
                res_cnt    = bbtt_pkg::CNT_W'(1);
            end
        end else if (i_dp_cmd.wb_upd) begin
            waddr    = idx_cur;
            res_slot = bbtt_pkg::SLOT_W'(r_idx);
            if (!idx_ok) begin
                res_status = bbtt_pkg::ST_ERROR;
            end else begin
                unique case (r_cmd)
                    bbtt_pkg::CMD_PIN: begin
                        if (cnt_q == bbtt_pkg::COUNT_MAX) begin
                            res_status = bbtt_pkg::ST_ERROR;
                            res_cnt    = cnt_q;
                        end else begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = cnt_q + 1'b1;
                            res_status = bbtt_pkg::ST_UPDATED;
                            res_cnt    = cnt_wdata;
                        end
                    end
                    bbtt_pkg::CMD_RELEASE, bbtt_pkg::CMD_UNPIN: begin
                        if (cnt_q == '0) begin
                            res_status = bbtt_pkg::ST_ERROR;
                        end else begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = cnt_q - 1'b1;
                            res_status = bbtt_pkg::ST_UPDATED;
                            res_cnt    = cnt_wdata;
                        end
                    end
                    default: begin
                        res_status = bbtt_pkg::ST_ERROR;
                    end
                endcase
            end
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            mem_tag[waddr] <= {r_dev, r_blk};
        end
        if (cnt_we) begin
            mem_cnt[waddr] <= cnt_wdata;
        end
    end

    // per-slot flags and victim pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_dvalid  <= '0;
            r_live    <= '0;
            r_vp      <= '0;
        end else begin
            if (cnt_we) begin
                r_live[waddr] <= 1'b1;
            end
            if (tag_we) begin
                r_present[waddr] <= 1'b1;
            end
            if (set_dv) begin
                r_dvalid[waddr] <= 1'b1;
            end
            if (vp_we) begin
                r_vp <= (free_sel == LAST_IDX) ? '0 : free_sel + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.wb_get || i_dp_cmd.wb_upd) begin
            r_slot   <= res_slot;
            r_status <= res_status;
            r_rd     <= res_rd;
            r_cnt    <= res_cnt;
        end
    end

    assign o_slot            = r_slot;
    assign o_status          = r_status;
    assign o_needs_disk_read = r_rd;
    assign o_reference_count = r_cnt;

endmodule

>>> rtl/block_buffer_tag_table.sv
// Buffer tag table with reference counts and round-robin replacement.
// Requests arrive on i_req (command, device, block_number, buffer_index) and
// one result per request leaves on o_rsp (slot, status, needs_disk_read,
// reference_count); both channels move a transaction when valid and ready
// are high at a rising edge of i_clk.
// A get scans every slot once, one slot a cycle through the registered read
// port of the tag and count memories, then resolves the request, updates the
// table where needed and loads the result register. Release, pin and unpin
// read only the indexed slot. The next request is taken only after the last
// one is written back, so the slot scan of a get sets the rate.
// Reset (i_rst_n low at a clock edge) clears the tag-present, data-valid and
// count-written flags of all slots and the victim pointer at once; the tag
// and count memories are not swept, so no clearing pass is needed.
// The result register holds one finished transaction. While o_rsp is
// stalled the block still accepts the next request and works it up to its
// table update, where it waits until the result register is free.
// Depends on bbtt_pkg, bbtt_if, bbtt_ctrl and bbtt_dp.
module block_buffer_tag_table #(
    parameter int BUFFER_COUNT = bbtt_pkg::BUFFER_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbtt_req_if.sink   i_req,
    bbtt_rsp_if.source o_rsp
);

    bbtt_pkg::t_dp_cmd dp_cmd;
    bbtt_pkg::t_dp_sts dp_sts;
    logic              in_ready;
    logic              out_valid;

    // controller
    bbtt_ctrl u_bbtt_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_command   (i_req.command),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_dp_cmd    (dp_cmd),
        .i_dp_sts    (dp_sts)
    );

    // datapath
    bbtt_dp #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_bbtt_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_dp_sts          (dp_sts),
        .i_command         (i_req.command),
        .i_device          (i_req.device),
        .i_block_number    (i_req.block_number),
        .i_buffer_index    (i_req.buffer_index),
        .o_slot            (o_rsp.slot),
        .o_status          (o_rsp.status),
        .o_needs_disk_read (o_rsp.needs_disk_read),
        .o_reference_count (o_rsp.reference_count)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

>>> rtl/bbtt_chk.sv
// port-level checker of the buffer tag table and its bind to the top level
// depends on bbtt_pkg and block_buffer_tag_table_macros.svh
`include "block_buffer_tag_table_macros.svh"

module bbtt_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input bbtt_pkg::t_slot   i_slot,
    input bbtt_pkg::t_status i_status,
    input logic              i_needs_disk_read,
    input bbtt_pkg::t_cnt    i_reference_count
);

    // a stalled result transaction holds its payload
    `BBTT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_slot) && $stable(i_status) && $stable(i_needs_disk_read) && $stable(i_reference_count), "result changed while stalled")

    // one request at a time: busy right after an accepted request
    `BBTT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request accepted while busy")

    // no free buffer reports zero fields
    `BBTT_ASSERT_NOW(a_nofree_zero, i_clk, i_rst_n, i_rsp_valid && (i_status == bbtt_pkg::ST_NOFREE), (i_slot == '0) && !i_needs_disk_read && (i_reference_count == '0), "no-free result with nonzero fields")

    // a freshly installed slot needs a read and holds one reference
    `BBTT_ASSERT_NOW(a_miss_fields, i_clk, i_rst_n, i_rsp_valid && (i_status == bbtt_pkg::ST_MISS), i_needs_disk_read && (i_reference_count == bbtt_pkg::CNT_W'(1)), "miss result with wrong fields")

    // count updates and errors never ask for a disk read
    `BBTT_ASSERT_NOW(a_no_read_on_update, i_clk, i_rst_n, i_rsp_valid && ((i_status == bbtt_pkg::ST_UPDATED) || (i_status == bbtt_pkg::ST_ERROR)), !i_needs_disk_read, "disk read flagged on count result")

endmodule

bind block_buffer_tag_table bbtt_chk u_bbtt_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_slot            (o_rsp.slot),
    .i_status          (o_rsp.status),
    .i_needs_disk_read (o_rsp.needs_disk_read),
    .i_reference_count (o_rsp.reference_count)
);
